@@ rtl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int unsigned LEN_W  = 6;
  localparam int unsigned TICK_W = 24;
  localparam int unsigned CFG_W  = 24;

  typedef logic [1:0] func_t;
  typedef logic [2:0] status_t;
  typedef logic [7:0] byte_t;
  typedef logic       cfg_idx_t;

  // item function codes
  localparam func_t FUNC_ARM  = 2'd0;
  localparam func_t FUNC_BYTE = 2'd1;
  localparam func_t FUNC_TICK = 2'd2;

  // result status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_TIMEOUT   = 3'd1;
  localparam status_t ST_TOO_LONG  = 3'd2;
  localparam status_t ST_BAD_END   = 3'd3;
  localparam status_t ST_BAD_CHECK = 3'd4;

  // configuration register indexes
  localparam cfg_idx_t CFG_MAX_LENGTH    = 1'b0;
  localparam cfg_idx_t CFG_TIMEOUT_TICKS = 1'b1;

  localparam byte_t MARK_START = 8'h02;
  localparam byte_t MARK_END   = 8'h03;

  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST    = 6'd32;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 24'd2000000;

  typedef struct packed {
    status_t status;
    logic    data_valid;
    byte_t   data_byte;
    logic    last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/cfr_in_if.sv @@
// ----------------------------------------------------------------------------
// cfr_in_if
// Input channel: function code and received byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_in_if;
  logic            valid;
  logic            ready;
  cfr_pkg::func_t  func;
  cfr_pkg::byte_t  rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/cfr_out_if.sv @@
// ----------------------------------------------------------------------------
// cfr_out_if
// Result channel: status, payload byte and last mark with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_out_if;
  logic             valid;
  logic             ready;
  cfr_pkg::status_t status;
  logic             data_valid;
  cfr_pkg::byte_t   data_byte;
  logic             last;

  modport source (output valid, output status, output data_valid, output data_byte,
                  output last, input ready);
  modport sink   (input valid, input status, input data_valid, input data_byte,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/cfr_ram.sv @@
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/checksummed_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Receives start/length/payload/check/end frames and gives out the payload.
// ----------------------------------------------------------------------------
// An arm item starts a receive; byte and tick items then advance the frame
// parser by one step each, one item per cycle while the result register is
// free. Payload bytes go into a MAX_BYTES-deep RAM with a registered read.
// Once a good frame ends, the payload is read back from that RAM and given
// out one byte per cycle (as fast as the result side takes it); input is
// held off for that drain. Failures and an empty good frame give a single
// status result marked last. The RAM needs no clearing: only entries
// written by the current frame are ever read.
`default_nettype none

module checksummed_frame_receiver #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cfr_in_if.sink                      rx_i,
  cfr_out_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  cfr_pkg::cfg_idx_t           cfg_idx_i,
  input  logic [cfr_pkg::CFG_W-1:0]   cfg_data_i
);

  import cfr_pkg::*;

  localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HUNT = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CHK  = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic [LEN_W-1:0]  frame_len_q, frame_len_d;
  logic [LEN_W-1:0]  byte_cnt_q, byte_cnt_d;
  byte_t             sum_q, sum_d;
  byte_t             chk_q, chk_d;
  logic [TICK_W-1:0] idle_q, idle_d;
  logic [LEN_W-1:0]  max_len_q;
  logic [TICK_W-1:0] timeout_q;
  logic              drain_q, drain_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic              out_free;
  logic              rx_acc;
  logic [LEN_W-1:0]  limit;
  logic [TICK_W-1:0] idle_inc;
  logic [LEN_W-1:0]  byte_inc;
  byte_t             chk_want;
  logic [AW-1:0]     rd_next;
  logic              rd_last;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_ra;
  byte_t             ram_rdata;

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES),
    .ADDR_W(AW)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(byte_cnt_q[AW-1:0]),
    .wdata_i(rx_i.rx_byte),
    .re_i   (ram_re),
    .raddr_i(ram_ra),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !out_valid_q || res_o.ready;
  assign rx_i.ready  = !drain_q && out_free;
  assign rx_acc      = rx_i.valid && rx_i.ready;
  assign limit       = (max_len_q < LEN_W'(MAX_BYTES)) ? max_len_q : LEN_W'(MAX_BYTES);
  assign idle_inc    = idle_q + 1'b1;
  assign byte_inc    = byte_cnt_q + 1'b1;
  assign chk_want    = 8'd0 - sum_q;
  assign rd_next     = rd_idx_q + 1'b1;
  assign rd_last     = (LEN_W'(rd_idx_q) + 1'b1) == frame_len_q;

  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    byte_cnt_d  = byte_cnt_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    idle_d      = idle_q;
    drain_d     = drain_q;
    pend_d      = pend_q;
    rd_idx_d    = rd_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_ra      = rd_idx_q;

    if (rx_acc) begin
      priority if (rx_i.func == FUNC_ARM) begin
        phase_d     = PH_HUNT;
        frame_len_d = '0;
        byte_cnt_d  = '0;
        sum_d       = '0;
        chk_d       = '0;
        idle_d      = '0;
      end else if (phase_q == PH_IDLE) begin
        // not armed: item dropped
      end else if (rx_i.func == FUNC_TICK) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_q) begin
          phase_d     = PH_IDLE;
          out_valid_d = 1'b1;
          out_d       = '{status: ST_TIMEOUT, data_valid: 1'b0, data_byte: 8'd0, last: 1'b1};
        end
      end else if (rx_i.func == FUNC_BYTE) begin
        idle_d = '0;
        unique case (phase_q)
          PH_HUNT: begin
            if (rx_i.rx_byte == MARK_START) begin
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (rx_i.rx_byte > 8'(limit)) begin
              phase_d     = PH_IDLE;
              out_valid_d = 1'b1;
              out_d       = '{status: ST_TOO_LONG, data_valid: 1'b0, data_byte: 8'd0,
                              last: 1'b1};
            end else begin
              frame_len_d = rx_i.rx_byte[LEN_W-1:0];
              sum_d       = rx_i.rx_byte;
              byte_cnt_d  = '0;
              phase_d     = (rx_i.rx_byte[LEN_W-1:0] == '0) ? PH_CHK : PH_DATA;
            end
          end
          PH_DATA: begin
            ram_we     = 1'b1;
            sum_d      = sum_q + rx_i.rx_byte;
            byte_cnt_d = byte_inc;
            if (byte_inc >= frame_len_q) begin
              phase_d = PH_CHK;
            end
          end
          PH_CHK: begin
            chk_d   = rx_i.rx_byte;
            phase_d = PH_END;
          end
          PH_END: begin
            phase_d = PH_IDLE;
            // end marker is judged before the check byte
            priority if (rx_i.rx_byte != MARK_END) begin
              out_valid_d = 1'b1;
              out_d       = '{status: ST_BAD_END, data_valid: 1'b0, data_byte: 8'd0,
                              last: 1'b1};
            end else if (chk_q != chk_want) begin
              out_valid_d = 1'b1;
              out_d       = '{status: ST_BAD_CHECK, data_valid: 1'b0, data_byte: 8'd0,
                              last: 1'b1};
            end else if (frame_len_q == '0) begin
              out_valid_d = 1'b1;
              out_d       = '{status: ST_OK, data_valid: 1'b0, data_byte: 8'd0, last: 1'b1};
            end else begin
              // start the payload drain with the first read
              drain_d  = 1'b1;
              pend_d   = 1'b1;
              rd_idx_d = '0;
              ram_re   = 1'b1;
              ram_ra   = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end else begin
        // reserved function code: item dropped
      end
    end else if (pend_q && out_free) begin
      // read data is ready: hand it over and fetch the next entry
      out_valid_d = 1'b1;
      out_d       = '{status: ST_OK, data_valid: 1'b1, data_byte: ram_rdata, last: rd_last};
      pend_d      = 1'b0;
      if (rd_last) begin
        drain_d = 1'b0;
      end else begin
        rd_idx_d = rd_next;
        ram_re   = 1'b1;
        ram_ra   = rd_next;
        pend_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      frame_len_q <= '0;
      byte_cnt_q  <= '0;
      sum_q       <= '0;
      chk_q       <= '0;
      idle_q      <= '0;
      drain_q     <= 1'b0;
      pend_q      <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      byte_cnt_q  <= byte_cnt_d;
      sum_q       <= sum_d;
      chk_q       <= chk_d;
      idle_q      <= idle_d;
      drain_q     <= drain_d;
      pend_q      <= pend_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LENGTH_RST;
      timeout_q <= TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LENGTH:    max_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_q.status;
  assign res_o.data_valid = out_q.data_valid;
  assign res_o.data_byte  = out_q.data_byte;
  assign res_o.last       = out_q.last;

  // a drain only runs after the parser has gone back to idle
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> phase_q == PH_IDLE)
    else $error("payload drain while parser active");

  // a read in flight belongs to a drain
  a_pend_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> drain_q)
    else $error("payload read outside drain");

  // the stored length never exceeds the payload RAM
  a_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_len_q <= LEN_W'(MAX_BYTES))
    else $error("frame length beyond payload store");

  // while collecting payload the count stays below the length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> byte_cnt_q < frame_len_q)
    else $error("payload count out of range");

  // no drain runs once the last payload byte is taken
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && res_o.data_valid && res_o.last |=> !drain_q)
    else $error("drain continues after last byte");

endmodule

`default_nettype wire
